>>> rtl/core/cta_pkg.sv
// shared constants for the chunk timestamp aligner
package cta_pkg;

    // field widths
    localparam int CHUNK_W = 9;
    localparam int TIME_W  = 63;
    localparam int WORD_W  = 64;

    // sample clock and timer scaling
    localparam int SAMPLE_RATE  = 48000;
    localparam int USEC_PER_SEC = 1000000;
    localparam int USEC_W       = $clog2(USEC_PER_SEC + 1);
    localparam int INCR_W       = CHUNK_W + USEC_W;

    // largest chunk accepted, larger counts saturate
    localparam int MAX_CHUNK = 256;

    // offset window
    localparam int WINDOW_DEPTH = 100;
    localparam int RING_AW      = $clog2(WINDOW_DEPTH);
    localparam int RING_CW      = $clog2(WINDOW_DEPTH + 1);

    // exponential average: weight (2^EMA_SHIFT - 1) / 2^EMA_SHIFT
    localparam int EMA_SHIFT = 7;

endpackage

>>> rtl/core/cta_div.sv
// reciprocal divider of a 64-bit word by the sample rate, one shared multiplier
module cta_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [cta_pkg::WORD_W-1:0] dividend,
    output logic                       busy,
    output logic [cta_pkg::WORD_W-1:0] quotient
);

    // rate splits into a power of two and an odd part: 48000 = 2^7 * 375
    localparam int POW2_SH  = 7;
    localparam int ODD_DIV  = cta_pkg::SAMPLE_RATE >> POW2_SH;
    localparam int Y_W      = cta_pkg::WORD_W - POW2_SH;
    localparam int HALF_W   = 29;
    localparam int RECIP_W  = 2 * HALF_W;
    localparam int RECIP_SH = Y_W + $clog2(ODD_DIV);
    localparam int ACC_W    = Y_W + RECIP_W;

    // rounded-up reciprocal, exact for every dividend of Y_W bits
    localparam logic [RECIP_SH:0]  POW_SH     = {1'b1, {RECIP_SH{1'b0}}};
    localparam logic [RECIP_SH:0]  RECIP_FULL = (POW_SH + ODD_DIV - 1) / ODD_DIV;
    localparam logic [RECIP_W-1:0] RECIP      = RECIP_FULL[RECIP_W-1:0];

    localparam logic [2:0] STEP_LAST = 3'd4;

    logic                  busy_reg;
    logic [2:0]            step_reg;
    logic [Y_W-1:0]        y_reg;
    logic [RECIP_W-1:0]    prod_reg;
    logic [1:0]            prod_idx_reg;
    logic [ACC_W-1:0]      acc_reg;
    logic [HALF_W-1:0]     mul_a;
    logic [HALF_W-1:0]     mul_b;
    logic [RECIP_W-1:0]    mul_p;
    logic [ACC_W-1:0]      placed;

    // half-word operands: bit 1 of the step picks the dividend half, bit 0 the reciprocal half
    assign mul_a = step_reg[1] ? HALF_W'(y_reg[Y_W-1:HALF_W]) : y_reg[HALF_W-1:0];
    assign mul_b = step_reg[0] ? RECIP[RECIP_W-1:HALF_W] : RECIP[HALF_W-1:0];
    assign mul_p = RECIP_W'(mul_a) * RECIP_W'(mul_b);

    // partial product moved up by one half per high operand
    assign placed = (prod_idx_reg[1] && prod_idx_reg[0]) ? (ACC_W'(prod_reg) << (2 * HALF_W))
                  : (prod_idx_reg[1] || prod_idx_reg[0]) ? (ACC_W'(prod_reg) << HALF_W)
                  : ACC_W'(prod_reg);

    // four products then one last sum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            step_reg <= '0;
        end else if (busy_reg) begin
            step_reg <= step_reg + 3'd1;
            if (step_reg == STEP_LAST) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // datapath: product of this step, sum of the previous one
    always_ff @(posedge aclk) begin
        if (start) begin
            y_reg   <= dividend[cta_pkg::WORD_W-1:POW2_SH];
            acc_reg <= '0;
        end else if (busy_reg) begin
            prod_reg     <= mul_p;
            prod_idx_reg <= step_reg[1:0];
            if (step_reg != '0) begin
                acc_reg <= acc_reg + placed;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = cta_pkg::WORD_W'(acc_reg[ACC_W-1:RECIP_SH]);

endmodule

>>> rtl/core/chunk_timestamp_aligner.sv
// chunk timestamp aligner: offset window minimum, smoothed clock offset
// the window scan (one memory read per entry, divide overlapped) is followed by the
//   offset, minimum and average steps; the scan covers only written entries while
//   filling, and the later average steps are skipped when the average is seeded
// one chunk at a time, s_ready high only while idle; a result held by m_ready stalls
//   the last step
module chunk_timestamp_aligner (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [cta_pkg::CHUNK_W-1:0]  s_chunk_samples,
    input  logic [cta_pkg::TIME_W-1:0]   s_arrival_time,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [cta_pkg::WORD_W-1:0]   m_chunk_start_time,
    output logic signed [cta_pkg::WORD_W-1:0] m_offset_estimate
);

    localparam int W  = cta_pkg::WORD_W;
    localparam int AW = cta_pkg::RING_AW;
    localparam int CW = cta_pkg::RING_CW;

    // sequencer states
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_ADD   = 4'd2;
    localparam logic [3:0] S_DIVGO = 4'd3;
    localparam logic [3:0] S_WAIT  = 4'd4;
    localparam logic [3:0] S_OFFS  = 4'd5;
    localparam logic [3:0] S_MIN   = 4'd6;
    localparam logic [3:0] S_EMA1  = 4'd7;
    localparam logic [3:0] S_EMA2  = 4'd8;
    localparam logic [3:0] S_EMA3  = 4'd9;
    localparam logic [3:0] S_START = 4'd10;

    logic [3:0]                   state_reg;
    logic [cta_pkg::CHUNK_W-1:0]  n_reg;
    logic [cta_pkg::TIME_W-1:0]   t_reg;
    logic [cta_pkg::INCR_W-1:0]   incr_reg;
    logic [W-1:0]                 prod_total_reg;
    logic [W-1:0]                 prev_exp_reg;
    logic [W-1:0]                 offset_reg;
    logic [W-1:0]                 smooth_reg;
    logic [W-1:0]                 acc_reg;
    logic [W-1:0]                 min_reg;
    logic [W-1:0]                 win_min_reg;
    logic                         min_valid_reg;
    logic [AW-1:0]                wpos_reg;
    logic                         full_reg;
    logic                         scan_active_reg;
    logic [CW-1:0]                scan_idx_reg;
    logic [CW-1:0]                scan_end_reg;
    logic                         rd_tag_reg;
    logic [W-1:0]                 rd_data_reg;
    logic                         m_valid_reg;
    logic [W-1:0]                 m_start_reg;
    logic [W-1:0]                 m_off_reg;
    logic [W-1:0]                 ring [cta_pkg::WINDOW_DEPTH];

    logic                         accept;
    logic                         div_start;
    logic                         div_busy;
    logic [W-1:0]                 div_quot;
    logic                         ring_we;
    logic [W-1:0]                 min_final;
    logic [W-1:0]                 ema_sum;
    logic [cta_pkg::CHUNK_W-1:0]  n_sat;

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign div_start = (state_reg == S_DIVGO);
    assign ring_we   = (state_reg == S_MIN);

    // oversized chunks saturate
    assign n_sat = (s_chunk_samples > cta_pkg::CHUNK_W'(cta_pkg::MAX_CHUNK))
                 ? cta_pkg::CHUNK_W'(cta_pkg::MAX_CHUNK) : s_chunk_samples;

    // window minimum including the new offset
    assign min_final = (min_valid_reg && ($signed(min_reg) < $signed(offset_reg)))
                     ? min_reg : offset_reg;

    // bias negative sums so the shift truncates toward zero
    assign ema_sum = acc_reg + (acc_reg[W-1] ? W'((1 << cta_pkg::EMA_SHIFT) - 1) : W'(0));

    // scaled sample count divided down to microseconds
    cta_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (prod_total_reg),
        .busy     (div_busy),
        .quotient (div_quot)
    );

    // offset window memory
    always_ff @(posedge aclk) begin
        if (ring_we) begin
            ring[wpos_reg] <= offset_reg;
        end
        rd_data_reg <= ring[scan_idx_reg[AW-1:0]];
    end

    // window scan over the entries that survive this beat's write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_active_reg <= 1'b0;
            rd_tag_reg      <= 1'b0;
            min_valid_reg   <= 1'b0;
            scan_idx_reg    <= '0;
        end else if (accept) begin
            scan_idx_reg    <= '0;
            scan_end_reg    <= full_reg ? CW'(cta_pkg::WINDOW_DEPTH) : CW'(wpos_reg);
            scan_active_reg <= full_reg || (wpos_reg != '0);
            rd_tag_reg      <= 1'b0;
            min_valid_reg   <= 1'b0;
        end else begin
            rd_tag_reg <= scan_active_reg && (scan_idx_reg != CW'(wpos_reg));
            if (scan_active_reg) begin
                scan_idx_reg <= scan_idx_reg + CW'(1);
                if (scan_idx_reg + CW'(1) == scan_end_reg) begin
                    scan_active_reg <= 1'b0;
                end
            end
            if (rd_tag_reg &&
                (!min_valid_reg || ($signed(rd_data_reg) < $signed(min_reg)))) begin
                min_reg       <= rd_data_reg;
                min_valid_reg <= 1'b1;
            end
        end
    end

    // sequencer and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            prod_total_reg <= '0;
            prev_exp_reg   <= '0;
            smooth_reg     <= '0;
            wpos_reg       <= '0;
            full_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != S_START)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (accept) begin
                        n_reg     <= n_sat;
                        t_reg     <= s_arrival_time;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL: begin
                    incr_reg  <= cta_pkg::INCR_W'(n_reg)
                               * cta_pkg::INCR_W'(cta_pkg::USEC_PER_SEC);
                    state_reg <= S_ADD;
                end
                S_ADD: begin
                    prod_total_reg <= prod_total_reg + W'(incr_reg);
                    state_reg      <= S_DIVGO;
                end
                S_DIVGO: begin
                    state_reg <= S_WAIT;
                end
                S_WAIT: begin
                    if (!div_busy && !scan_active_reg && !rd_tag_reg) begin
                        state_reg <= S_OFFS;
                    end
                end
                S_OFFS: begin
                    offset_reg <= {1'b0, t_reg} - div_quot;
                    state_reg  <= S_MIN;
                end
                S_MIN: begin
                    win_min_reg <= min_final;
                    if (wpos_reg == AW'(cta_pkg::WINDOW_DEPTH - 1)) begin
                        wpos_reg <= '0;
                        full_reg <= 1'b1;
                    end else begin
                        wpos_reg <= wpos_reg + AW'(1);
                    end
                    state_reg <= S_EMA1;
                end
                S_EMA1: begin
                    if (smooth_reg == '0) begin
                        smooth_reg <= win_min_reg;
                        state_reg  <= S_START;
                    end else begin
                        acc_reg   <= (smooth_reg << cta_pkg::EMA_SHIFT) - smooth_reg;
                        state_reg <= S_EMA2;
                    end
                end
                S_EMA2: begin
                    acc_reg   <= acc_reg + win_min_reg;
                    state_reg <= S_EMA3;
                end
                S_EMA3: begin
                    smooth_reg <= W'($signed(ema_sum) >>> cta_pkg::EMA_SHIFT);
                    state_reg  <= S_START;
                end
                S_START: begin
                    // load the output register once the previous beat has gone
                    if (!m_valid_reg || m_ready) begin
                        m_start_reg  <= smooth_reg + prev_exp_reg;
                        m_off_reg    <= smooth_reg;
                        m_valid_reg  <= 1'b1;
                        prev_exp_reg <= div_quot;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_chunk_start_time = m_start_reg;
    assign m_offset_estimate  = $signed(m_off_reg);

    // a result appears only from the final sequencer step
    a_result_from_start: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == S_START)
        else $error("result raised outside the output step");

    // the divider is never restarted mid-division
    a_div_idle_at_start: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    // offset is formed only once quotient and window scan are complete
    a_offs_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_OFFS |-> !div_busy && !scan_active_reg && !rd_tag_reg)
        else $error("offset formed before divide and scan finished");

    // write pointer stays inside the window
    a_wpos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wpos_reg < AW'(cta_pkg::WINDOW_DEPTH))
        else $error("window pointer out of range");

endmodule

>>> verif/tb.sv
// self-checking testbench for the chunk timestamp aligner: directed table, then random streams
`timescale 1ns / 100ps

module tb;

    localparam int DIR_N      = 16;
    localparam int RAND_ITEMS = 1334;
    localparam int DRAIN_CYC  = 200;

    typedef struct packed {
        logic [cta_pkg::WORD_W-1:0] start;
        logic [cta_pkg::WORD_W-1:0] offs;
    } aligned_t;

    typedef struct packed {
        logic [cta_pkg::CHUNK_W-1:0] n;
        logic [cta_pkg::TIME_W-1:0]  t;
        logic                        typed;
        logic [cta_pkg::WORD_W-1:0]  start;
        logic [cta_pkg::WORD_W-1:0]  offs;
    } chunk_row_t;

    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [cta_pkg::CHUNK_W-1:0]        s_chunk_samples = '0;
    logic [cta_pkg::TIME_W-1:0]         s_arrival_time = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic [cta_pkg::WORD_W-1:0]         m_chunk_start_time;
    logic signed [cta_pkg::WORD_W-1:0]  m_offset_estimate;

    // predictor state
    logic [cta_pkg::WORD_W-1:0] samples_seen = '0;
    logic [cta_pkg::WORD_W-1:0] offset_window [cta_pkg::WINDOW_DEPTH];
    int                         window_wr = 0;
    bit                         window_full = 1'b0;
    logic [cta_pkg::WORD_W-1:0] offset_avg = '0;

    aligned_t expected_beats [$];
    aligned_t head_beat;
    int       fault_count = 0;
    int       stall_left = 0;
    bit       rx_calm = 1'b0;

    // directed rows: typed results only where they follow at a glance
    chunk_row_t dir_rows [DIR_N] = '{
        // first beat seeds the average directly
        '{9'd0,   63'd1, 1'b1, 64'd1, 64'd1},
        // average lands exactly on zero
        '{9'd7,   63'd19, 1'b1, 64'd0, 64'd0},
        // zero average reloads the window minimum
        '{9'd0,   63'd145, 1'b1, 64'd19, 64'hFFFF_FFFF_FFFF_FF82},
        // oversized chunk saturates, largest timer value
        '{9'd300, 63'h7FFF_FFFF_FFFF_FFFF, 1'b1, 64'd19, 64'hFFFF_FFFF_FFFF_FF82},
        '{9'd511, 63'd0, 1'b0, '0, '0},
        '{9'd1,   63'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0, '0},
        '{9'd256, 63'h5555_5555_5555_5555, 1'b0, '0, '0},
        '{9'd257, 63'h4000_0000_0000_0000, 1'b0, '0, '0},
        '{9'd255, 63'h7FFF_FFFF_FFFF_FFFE, 1'b0, '0, '0},
        '{9'd128, 63'd20000, 1'b0, '0, '0},
        '{9'd0,   63'd0, 1'b0, '0, '0},
        '{9'd256, 63'd26000, 1'b0, '0, '0},
        '{9'd170, 63'h0000_0001_0000_0000, 1'b0, '0, '0},
        '{9'd341, 63'h3FFF_FFFF_FFFF_FFFF, 1'b0, '0, '0},
        '{9'd64,  63'h0123_4567_89AB_CDEF, 1'b0, '0, '0},
        '{9'd256, 63'd1, 1'b0, '0, '0}
    };

    chunk_timestamp_aligner dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_chunk_samples    (s_chunk_samples),
        .s_arrival_time     (s_arrival_time),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_chunk_start_time (m_chunk_start_time),
        .m_offset_estimate  (m_offset_estimate)
    );

    always #6 aclk = ~aclk;

    // microseconds covered by a sample count, wrapping at 64 bits
    function automatic logic [cta_pkg::WORD_W-1:0] usec_of(
            input logic [cta_pkg::WORD_W-1:0] count);
        return (count * 64'(cta_pkg::USEC_PER_SEC)) / 64'(cta_pkg::SAMPLE_RATE);
    endfunction

    function automatic logic [cta_pkg::WORD_W-1:0] clip_chunk(
            input logic [cta_pkg::CHUNK_W-1:0] n);
        return (n > cta_pkg::MAX_CHUNK) ? 64'(cta_pkg::MAX_CHUNK) : 64'(n);
    endfunction

    // offset window minimum and smoothed offset for one chunk
    function automatic aligned_t align_chunk(input logic [cta_pkg::CHUNK_W-1:0] n_in,
                                             input logic [cta_pkg::TIME_W-1:0] t);
        logic [cta_pkg::WORD_W-1:0] n, due, offs, low, acc;
        int                         span;
        aligned_t                   res;
        n = clip_chunk(n_in);
        due = usec_of(samples_seen + n);
        offs = {1'b0, t} - due;
        offset_window[window_wr] = offs;
        window_wr++;
        if (window_wr >= cta_pkg::WINDOW_DEPTH) begin
            window_wr = 0;
            window_full = 1'b1;
        end
        // minimum over written entries only
        low = offs;
        span = window_full ? cta_pkg::WINDOW_DEPTH : window_wr;
        for (int i = 0; i < span; i++) begin
            if ($signed(offset_window[i]) < $signed(low))
                low = offset_window[i];
        end
        // zero average means unseeded, load the minimum
        if (offset_avg == '0) begin
            offset_avg = low;
        end else begin
            acc = offset_avg * 64'd127 + low;
            offset_avg = $signed(acc) / 64'sd128;
        end
        res.start = offset_avg + usec_of(samples_seen);
        res.offs = offset_avg;
        samples_seen = samples_seen + n;
        return res;
    endfunction

    // sender gap: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 4);
        if (r < 95) return $urandom_range(5, 30);
        return $urandom_range(60, 250);
    endfunction

    // drive one beat, hold until accepted, log the expectation, then wait out the gap
    task automatic push_chunk(input logic [cta_pkg::CHUNK_W-1:0] n,
                              input logic [cta_pkg::TIME_W-1:0] t,
                              input logic typed, input aligned_t typed_beat, input int gap);
        aligned_t pred;
        s_valid <= 1'b1;
        s_chunk_samples <= n;
        s_arrival_time <= t;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = align_chunk(n, t);
        expected_beats.push_back(typed ? typed_beat : pred);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold the sender until every result is back
    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_beats.size() != 0) @(posedge aclk);
    endtask

    // result checking and receiver stalls
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat, start %h offset %h", $time,
                         m_chunk_start_time, m_offset_estimate);
                fault_count++;
            end else begin
                head_beat = expected_beats.pop_front();
                if (m_chunk_start_time !== head_beat.start) begin
                    $display("%0t: chunk_start_time expected %h actual %h", $time,
                             head_beat.start, m_chunk_start_time);
                    fault_count++;
                end
                if (m_offset_estimate !== head_beat.offs) begin
                    $display("%0t: offset_estimate expected %h actual %h", $time,
                             head_beat.offs, m_offset_estimate);
                    fault_count++;
                end
            end
        end
        if (rx_calm) begin
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 99) < 70) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b0;
            stall_left = ($urandom_range(0, 99) < 90) ? $urandom_range(0, 3)
                                                      : $urandom_range(40, 250);
        end
    end

    // stimulus
    initial begin
        int                          sent, plen, kind, r;
        bit                          calm;
        logic [cta_pkg::CHUNK_W-1:0] n;
        logic [cta_pkg::TIME_W-1:0]  t;
        logic [cta_pkg::WORD_W-1:0]  due, base;
        aligned_t                    typed_beat;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int i = 0; i < DIR_N; i++) begin
            typed_beat.start = dir_rows[i].start;
            typed_beat.offs = dir_rows[i].offs;
            push_chunk(dir_rows[i].n, dir_rows[i].t, dir_rows[i].typed, typed_beat,
                       pick_gap());
        end
        drain_results();

        // random streams in phases of one offset regime each
        sent = 0;
        base = '0;
        while (sent < RAND_ITEMS) begin
            plen = $urandom_range(60, 180);
            kind = $urandom_range(0, 3);
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0)
                drain_results();
            rx_calm <= calm;
            case (kind)
                0: base = 64'($urandom_range(0, 5000));
                2: base = {($urandom & 32'h3FFF_FFFF) | 32'h4000_0000, $urandom};
                default: base = '0;
            endcase
            for (int k = 0; k < plen && sent < RAND_ITEMS; k++) begin
                r = $urandom_range(0, 99);
                if (r < 10) begin
                    // noise beat
                    n = cta_pkg::CHUNK_W'($urandom);
                    t = cta_pkg::TIME_W'({$urandom, $urandom});
                end else begin
                    if (r < 75)
                        n = cta_pkg::CHUNK_W'($urandom_range(100, 256));
                    else if (r < 93)
                        n = cta_pkg::CHUNK_W'($urandom_range(0, 511));
                    else if (r < 97)
                        n = cta_pkg::CHUNK_W'(cta_pkg::MAX_CHUNK);
                    else
                        n = '0;
                    due = usec_of(samples_seen + clip_chunk(n));
                    case (kind)
                        1: t = cta_pkg::TIME_W'(due - 64'($urandom_range(1, 3000)));
                        3: t = {cta_pkg::TIME_W{1'b1}}
                             - cta_pkg::TIME_W'($urandom_range(0, 1000));
                        default: t = cta_pkg::TIME_W'(due + base
                                                      + 64'($urandom_range(0, 400)));
                    endcase
                end
                typed_beat = '0;
                push_chunk(n, t, 1'b0, typed_beat, calm ? 0 : pick_gap());
                sent++;
            end
        end
        rx_calm <= 1'b0;
        drain_results();
        repeat (DRAIN_CYC) @(posedge aclk);

        if (fault_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // run limit
    initial begin
        #60_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/cta_pkg.sv
rtl/core/cta_div.sv
rtl/core/chunk_timestamp_aligner.sv
verif/tb.sv
